### design/vlm_pkg.sv
// Package: shared types and codes for the vector lane MAC ALU.
`default_nettype none
package vlm_pkg;

  // Operation codes of the input action field
  typedef enum logic [4:0] {
    ACT_MULF = 5'd0,  ACT_MULU = 5'd1,  ACT_MACF = 5'd2,  ACT_MACU = 5'd3,
    ACT_MUDL = 5'd4,  ACT_MADL = 5'd5,  ACT_MUDM = 5'd6,  ACT_MADM = 5'd7,
    ACT_MUDN = 5'd8,  ACT_MADN = 5'd9,  ACT_MUDH = 5'd10, ACT_MADH = 5'd11,
    ACT_ADD  = 5'd12, ACT_SUB  = 5'd13, ACT_ABS  = 5'd14, ACT_ADDC = 5'd15,
    ACT_SUBC = 5'd16, ACT_LT   = 5'd17, ACT_EQ   = 5'd18, ACT_NE   = 5'd19,
    ACT_GE   = 5'd20, ACT_MRG  = 5'd21, ACT_CLIP = 5'd22, ACT_RDH  = 5'd23,
    ACT_RDM  = 5'd24, ACT_RDL  = 5'd25, ACT_AND  = 5'd26, ACT_NAND = 5'd27,
    ACT_OR   = 5'd28, ACT_NOR  = 5'd29, ACT_XOR  = 5'd30, ACT_NXOR = 5'd31
  } vlm_action_t;

  // Operation class chosen by the front end
  typedef enum logic [3:0] {
    CL_MUL, CL_ADDSUB, CL_ABS, CL_CARRY, CL_CMP, CL_MERGE, CL_CLIP, CL_ACCRD, CL_LOGIC
  } vlm_class_t;

  localparam int unsigned LANE_IDX_W = 4;

  localparam logic [15:0] S16_MIN = 16'h8000;
  localparam logic [15:0] S16_MAX = 16'h7FFF;
  localparam logic [15:0] U16_MAX = 16'hFFFF;

  typedef struct packed {
    logic [4:0]  action;
    logic [2:0]  lane;
    logic [15:0] vs_value;
    logic [15:0] vt_value;
  } vlm_in_t;

  typedef struct packed {
    logic [15:0] dest_value;
    logic        carry_flag;
    logic        not_equal_flag;
    logic        compare_low_flag;
    logic        compare_high_flag;
    logic        clip_extra_flag;
  } vlm_out_t;

  // Decoded item handed from the front end to the execute stage
  typedef struct packed {
    vlm_action_t           action;
    vlm_class_t            cls;
    logic [LANE_IDX_W-1:0] lane;
    logic [15:0]           vs;
    logic [15:0]           vt;
  } vlm_op_t;

endpackage
`default_nettype wire

### design/vlm_fifo.sv
// Two-entry queue used between the front end, the execute stage and the result port.
`default_nettype none
module vlm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Store the incoming transfer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

### design/vlm_front.sv
// Front end: classify each accepted item and fold its lane index into range.
`default_nettype none
module vlm_front
  import vlm_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  wire vlm_in_t in_item,
  output vlm_op_t      op
);

  logic [4:0] lane_v;

  // Reduce the lane index modulo the lane count
  always_comb begin
    lane_v = {2'b00, in_item.lane};
    for (int i = 0; i < 8; i++) begin
      if (lane_v >= 5'(LANES)) lane_v = lane_v - 5'(LANES);
    end
  end

  // Decode the operation class
  always_comb begin
    op.action = vlm_action_t'(in_item.action);
    op.lane   = lane_v[LANE_IDX_W-1:0];
    op.vs     = in_item.vs_value;
    op.vt     = in_item.vt_value;
    unique case (vlm_action_t'(in_item.action)) inside
      [ACT_MULF:ACT_MADH]:  op.cls = CL_MUL;
      ACT_ADD, ACT_SUB:     op.cls = CL_ADDSUB;
      ACT_ABS:              op.cls = CL_ABS;
      ACT_ADDC, ACT_SUBC:   op.cls = CL_CARRY;
      [ACT_LT:ACT_GE]:      op.cls = CL_CMP;
      ACT_MRG:              op.cls = CL_MERGE;
      ACT_CLIP:             op.cls = CL_CLIP;
      [ACT_RDH:ACT_RDL]:    op.cls = CL_ACCRD;
      default:              op.cls = CL_LOGIC;
    endcase
  end

endmodule
`default_nettype wire

### design/vlm_back.sv
// Execute stage: per-lane accumulators, flag state and the lane arithmetic.
`default_nettype none
module vlm_back
  import vlm_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire vlm_op_t op,
  output vlm_out_t     res
);

  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [47:0]      acc_r [LANES];
  logic [LANES-1:0] carry_lo_r, carry_hi_r, cmp_lo_r, cmp_hi_r, clip_r;

  logic [LW-1:0]    li;
  logic [47:0]      acc_cur, acc_nxt, acc_base, term, acc_mul;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic [31:0]      hm;
  logic             hm_lo_ovf, hm_hi_ovf, hm_neg;
  logic             clo, chi;
  logic             clo_nxt, chi_nxt, cmlo_nxt, cmhi_nxt, clip_nxt;
  logic [15:0]      d;
  logic             wlow;
  logic signed [17:0] r;
  logic [16:0]      sum;
  logic             cond;
  logic             sg, ge, le, ce, ne;
  logic [15:0]      nt, df, neg;
  logic signed [15:0] s, t;

  assign li      = op.lane[LW-1:0];
  assign acc_cur = acc_r[li];
  assign clo     = carry_lo_r[li];
  assign chi     = carry_hi_r[li];
  assign s       = op.vs;
  assign t       = op.vt;

  // Select multiplier operand signedness
  always_comb begin
    ma = {op.vs[15], op.vs};
    mb = {op.vt[15], op.vt};
    case (op.action)
      ACT_MUDL, ACT_MADL: begin
        ma = {1'b0, op.vs};
        mb = {1'b0, op.vt};
      end
      ACT_MUDM, ACT_MADM: mb = {1'b0, op.vt};
      ACT_MUDN, ACT_MADN: ma = {1'b0, op.vs};
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // Scale the product into an accumulator term and add
  always_comb begin
    case (op.action)
      ACT_MULF, ACT_MULU: term = ({{14{prod[33]}}, prod} << 1) + 48'h8000;
      ACT_MACF, ACT_MACU: term = {{14{prod[33]}}, prod} << 1;
      ACT_MUDL, ACT_MADL: term = {32'd0, prod[31:16]};
      ACT_MUDH, ACT_MADH: term = {{14{prod[33]}}, prod} << 16;
      default:            term = {{14{prod[33]}}, prod};
    endcase
    acc_base = ((op.action < ACT_MACF) || ((op.action >= ACT_MUDL) && !op.action[0]))
               ? 48'd0 : acc_cur;
  end

  assign acc_mul   = acc_base + term;
  assign hm        = acc_mul[47:16];
  assign hm_neg    = hm[31];
  assign hm_lo_ovf = hm[31] && !(&hm[30:15]);
  assign hm_hi_ovf = !hm[31] && (|hm[30:15]);

  // Compute the lane result and the new lane state
  always_comb begin
    acc_nxt  = acc_cur;
    d        = 16'd0;
    wlow     = 1'b1;
    clo_nxt  = clo;
    chi_nxt  = chi;
    cmlo_nxt = cmp_lo_r[li];
    cmhi_nxt = cmp_hi_r[li];
    clip_nxt = clip_r[li];
    r        = 18'sd0;
    sum      = 17'd0;
    cond     = 1'b0;
    neg      = 16'd0 - op.vt;
    sg       = op.vs[15] ^ op.vt[15];
    nt       = sg ? neg : op.vt;
    df       = op.vs - nt;
    ge       = sg ? op.vt[15] : !df[15];
    le       = sg ? (df[15] || (df == 16'd0)) : op.vt[15];
    ce       = sg && (df == U16_MAX);
    ne       = !((df == 16'd0) || ce);
    unique case (op.cls)
      CL_MUL: begin
        wlow    = 1'b0;
        acc_nxt = acc_mul;
        case (op.action)
          ACT_MULU, ACT_MACU:
            d = hm_neg ? 16'd0 : ((|hm[30:15]) ? U16_MAX : hm[15:0]);
          ACT_MUDL, ACT_MADL, ACT_MUDN, ACT_MADN:
            d = hm_lo_ovf ? 16'd0 : (hm_hi_ovf ? U16_MAX : acc_mul[15:0]);
          default:
            d = hm_lo_ovf ? S16_MIN : (hm_hi_ovf ? S16_MAX : hm[15:0]);
        endcase
      end
      CL_ADDSUB: begin
        wlow = 1'b0;
        if (op.action == ACT_ADD) r = 18'(s) + 18'(t) + {17'd0, clo};
        else                      r = 18'(s) - 18'(t) - {17'd0, clo};
        acc_nxt = {acc_cur[47:16], r[15:0]};
        if (r < -18'sd32768)     d = S16_MIN;
        else if (r > 18'sd32767) d = S16_MAX;
        else                     d = r[15:0];
        clo_nxt = 1'b0;
        chi_nxt = 1'b0;
      end
      CL_ABS: begin
        wlow = 1'b0;
        if (op.vs[15]) begin
          d       = (op.vt == S16_MIN) ? S16_MAX : neg;
          acc_nxt = {acc_cur[47:16], neg};
        end else if (op.vs == 16'd0) begin
          d       = 16'd0;
          acc_nxt = {acc_cur[47:16], 16'd0};
        end else begin
          d       = op.vt;
          acc_nxt = {acc_cur[47:16], op.vt};
        end
      end
      CL_CARRY: begin
        if (op.action == ACT_ADDC) begin
          sum     = {1'b0, op.vs} + {1'b0, op.vt};
          d       = sum[15:0];
          clo_nxt = sum[16];
          chi_nxt = 1'b0;
        end else begin
          d       = op.vs - op.vt;
          clo_nxt = op.vs < op.vt;
          chi_nxt = op.vs != op.vt;
        end
      end
      CL_CMP: begin
        case (op.action)
          ACT_LT:  cond = (s < t) || ((s == t) && clo && chi);
          ACT_EQ:  cond = (s == t) && !chi;
          ACT_NE:  cond = (s != t) || chi;
          default: cond = (s > t) || ((s == t) && !(clo && chi));
        endcase
        d        = cond ? op.vs : op.vt;
        cmlo_nxt = cond;
        cmhi_nxt = 1'b0;
        clo_nxt  = 1'b0;
        chi_nxt  = 1'b0;
      end
      CL_MERGE: begin
        d       = cmp_lo_r[li] ? op.vs : op.vt;
        clo_nxt = 1'b0;
        chi_nxt = 1'b0;
      end
      CL_CLIP: begin
        d        = (sg ? le : ge) ? nt : op.vs;
        cmlo_nxt = le;
        cmhi_nxt = ge;
        clo_nxt  = sg;
        chi_nxt  = ne;
        clip_nxt = ce;
      end
      CL_ACCRD: begin
        wlow = 1'b0;
        case (op.action)
          ACT_RDH: d = acc_cur[47:32];
          ACT_RDM: d = acc_cur[31:16];
          default: d = acc_cur[15:0];
        endcase
      end
      default: begin
        case (op.action)
          ACT_AND:  d = op.vs & op.vt;
          ACT_NAND: d = ~(op.vs & op.vt);
          ACT_OR:   d = op.vs | op.vt;
          ACT_NOR:  d = ~(op.vs | op.vt);
          ACT_XOR:  d = op.vs ^ op.vt;
          default:  d = ~(op.vs ^ op.vt);
        endcase
      end
    endcase
    if (wlow) acc_nxt = {acc_cur[47:16], d};
  end

  // Present the result with the lane's updated flags
  always_comb begin
    res.dest_value        = d;
    res.carry_flag        = clo_nxt;
    res.not_equal_flag    = chi_nxt;
    res.compare_low_flag  = cmlo_nxt;
    res.compare_high_flag = cmhi_nxt;
    res.clip_extra_flag   = clip_nxt;
  end

  // Commit lane state on each executed transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) acc_r[i] <= 48'd0;
      carry_lo_r <= '0;
      carry_hi_r <= '0;
      cmp_lo_r   <= '0;
      cmp_hi_r   <= '0;
      clip_r     <= '0;
    end else if (fire) begin
      acc_r[li]      <= acc_nxt;
      carry_lo_r[li] <= clo_nxt;
      carry_hi_r[li] <= chi_nxt;
      cmp_lo_r[li]   <= cmlo_nxt;
      cmp_hi_r[li]   <= cmhi_nxt;
      clip_r[li]     <= clip_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cmp_clears_carry: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op.cls == CL_CMP) |-> !res.carry_flag && !res.not_equal_flag
                                   && !res.compare_high_flag)
    else $error("compare left carry or high compare flag set");
  a_clip_ext_sign: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op.cls == CL_CLIP) && res.clip_extra_flag |-> res.carry_flag)
    else $error("clip extension without sign difference");
  a_read_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op.cls == CL_ACCRD) |=> (acc_r[$past(li)] == $past(acc_cur)))
    else $error("accumulator read changed the accumulator");
  a_addc_ne_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op.action == ACT_ADDC) |=> !carry_hi_r[$past(li)])
    else $error("add with carry left the high carry bit set");
`endif

endmodule
`default_nettype wire

### design/vector_lane_mac_alu.sv
// Top level: one lane of a fixed-point SIMD multiply-accumulate vector ALU.
// Accepts one lane operation per clock unless full and returns one result per
// clock while popped. A pushed item enters a two-entry operation queue, runs in
// the execute stage (one 17x17 multiplier, 48-bit accumulator add and clamp)
// once the result queue has room, and is registered into the two-entry result
// queue; each of the two queues absorbs stalls on its side. Lane state updates
// in the cycle it is read, so consecutive items on one lane need no spacing.
`default_nettype none
module vector_lane_mac_alu
  import vlm_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire vlm_in_t in_item,
  input  wire logic    push,
  output logic         full,
  output vlm_out_t     out_item,
  output logic         empty,
  input  wire logic    pop
);

  vlm_op_t  op_in, op_q;
  logic [$bits(vlm_op_t)-1:0]  op_q_bits;
  logic [$bits(vlm_out_t)-1:0] out_bits;
  vlm_out_t res;
  logic     q_empty, o_full, fire;

  // Classify incoming items
  vlm_front #(.LANES(LANES)) u_front (
    .in_item (in_item),
    .op      (op_in)
  );

  // Hold decoded operations between front and execute
  vlm_fifo #(.WIDTH($bits(vlm_op_t))) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (op_in),
    .full    (full),
    .rd_en   (fire),
    .rd_data (op_q_bits),
    .empty   (q_empty)
  );

  assign op_q = vlm_op_t'(op_q_bits);
  assign fire = !q_empty && !o_full;

  // Execute one lane operation per cycle while one is queued and the result queue has room
  vlm_back #(.LANES(LANES)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .op    (op_q),
    .res   (res)
  );

  // Hold results until the consumer takes the transfer
  vlm_fifo #(.WIDTH($bits(vlm_out_t))) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fire),
    .wr_data (res),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty)
  );

  assign out_item = vlm_out_t'(out_bits);

endmodule
`default_nettype wire
